>>> rtl/core/spom_pkg.sv
// ----------------------------------------------------------------------------
// spom_pkg
// Shared constants and types of the spiral-order matrix reader.
// ----------------------------------------------------------------------------
package spom_pkg;

  localparam int MAX_ROWS_DEF    = 8;
  localparam int MAX_COLUMNS_DEF = 8;
  localparam int DATA_WIDTH_DEF  = 32;

  // configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_e;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } walk_dir_e;

  typedef struct packed {
    logic start;
  } walk_ctrl_t;

  typedef struct packed {
    logic busy;
    logic rd_en;
    logic last;
  } walk_stat_t;

endpackage

>>> rtl/core/spiral_order_matrix_reader.sv
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader
// Loads a matrix row-major, then streams it out in clockwise spiral order.
// ----------------------------------------------------------------------------
// Load: one element per cycle while busy_o is low; busy_o stays low between elements.
// Drain: after the final element the walker enters its run state, then the
// registered store read gives one beat per cycle, rows*columns beats.
// busy_o is high while the walker issues the rows*columns store reads.
// Reset clears the load count and control; sizes return to 1 by 1; store
// contents are undefined until written. The receiver cannot stall.
module spiral_order_matrix_reader #(
  parameter int MAX_ROWS    = spom_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = spom_pkg::MAX_COLUMNS_DEF,
  parameter int DATA_WIDTH  = spom_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [DATA_WIDTH-1:0]  element_value_i,
  output logic                          spiral_valid_o,
  output logic signed [DATA_WIDTH-1:0]  spiral_value_o,
  output logic                          is_last_o,
  input  logic                          cfg_we_i,
  input  logic [spom_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [spom_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import spom_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int CW     = $clog2(MAX_COLUMNS + 1);

  logic [CFG_W-1:0] row_count_q, row_count_d, column_count_q, column_count_d;
  logic [CNT_W-1:0] loaded_q, loaded_d, loaded_inc, total;
  logic [RW-1:0]    rows_eff;
  logic [CW-1:0]    cols_eff;
  logic             accept, trigger;
  logic             valid_q, last_q;

  walk_ctrl_t        walk_ctrl;
  walk_stat_t        walk_stat;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = RW'(1);
    end else if (row_count_q > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(row_count_q);
    end
    if (column_count_q == '0) begin
      cols_eff = CW'(1);
    end else if (column_count_q > MAX_COLUMNS) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = CW'(column_count_q);
    end
  end

  assign total      = CNT_W'(rows_eff) * CNT_W'(cols_eff);
  assign accept     = start_i && !walk_stat.busy;
  assign loaded_inc = loaded_q + CNT_W'(1);
  assign trigger    = accept && (loaded_inc >= total);

  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ROW_COUNT:    row_count_d    = cfg_wdata_i;
        REG_COLUMN_COUNT: column_count_d = cfg_wdata_i;
        default: ;
      endcase
    end
    loaded_d = loaded_q;
    if (trigger) begin
      loaded_d = '0;
    end else if (accept) begin
      loaded_d = loaded_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CFG_W'(1);
      column_count_q <= CFG_W'(1);
      loaded_q       <= '0;
      valid_q        <= 1'b0;
      last_q         <= 1'b0;
    end else begin
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
      loaded_q       <= loaded_d;
      valid_q        <= walk_stat.rd_en;
      last_q         <= walk_stat.rd_en && walk_stat.last;
    end
  end

  assign walk_ctrl.start = trigger;

  spom_walker #(
    .RW     (RW),
    .CW     (CW),
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (walk_ctrl),
    .rows_i    (rows_eff),
    .cols_i    (cols_eff),
    .total_i   (total),
    .stat_o    (walk_stat),
    .rd_addr_o (rd_addr)
  );

  spom_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (loaded_q[ADDR_W-1:0]),
    .wdata_i (element_value_i),
    .re_i    (walk_stat.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign busy_o         = walk_stat.busy;
  assign spiral_valid_o = valid_q;
  assign spiral_value_o = rd_data;
  assign is_last_o      = last_q;

endmodule

>>> rtl/core/spom_store.sv
// ----------------------------------------------------------------------------
// spom_store
// Element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spom_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int ADDR_W     = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/spom_walker.sv
// ----------------------------------------------------------------------------
// spom_walker
// Spiral address sequencer: bounds, direction and a single address adder
// that steps by one or by the row pitch each cycle.
// ----------------------------------------------------------------------------
module spom_walker #(
  parameter int RW     = 4,
  parameter int CW     = 4,
  parameter int CNT_W  = 7,
  parameter int ADDR_W = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spom_pkg::walk_ctrl_t     ctrl_i,
  input  logic [RW-1:0]            rows_i,
  input  logic [CW-1:0]            cols_i,
  input  logic [CNT_W-1:0]         total_i,
  output spom_pkg::walk_stat_t     stat_o,
  output logic [ADDR_W-1:0]        rd_addr_o
);

  import spom_pkg::*;

  walk_state_e state_q, state_d;
  walk_dir_e   dir_q, dir_d;

  logic [RW-1:0]     r_q, r_d, top_q, top_d, bottom_q, bottom_d;
  logic [CW-1:0]     c_q, c_d, left_q, left_d, right_q, right_d;
  logic [CW-1:0]     cols_q, cols_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic              one_sel, sub_sel, last;
  logic [ADDR_W-1:0] step_op, step_addr;

  // shared address adder
  always_comb begin
    step_op   = one_sel ? ADDR_W'(1) : ADDR_W'(cols_q);
    step_addr = sub_sel ? (addr_q + ~step_op + ADDR_W'(1)) : (addr_q + step_op);
  end

  assign last = (remain_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WALK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q    <= dir_d;
    r_q      <= r_d;
    c_q      <= c_d;
    top_q    <= top_d;
    bottom_q <= bottom_d;
    left_q   <= left_d;
    right_q  <= right_d;
    cols_q   <= cols_d;
    remain_q <= remain_d;
    addr_q   <= addr_d;
  end

  always_comb begin
    state_d  = state_q;
    dir_d    = dir_q;
    r_d      = r_q;
    c_d      = c_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    left_d   = left_q;
    right_d  = right_q;
    cols_d   = cols_q;
    remain_d = remain_q;
    addr_d   = addr_q;
    one_sel  = 1'b1;
    sub_sel  = 1'b0;

    unique case (state_q)
      WALK_IDLE: begin
        if (ctrl_i.start) begin
          state_d  = WALK_RUN;
          dir_d    = DIR_RIGHT;
          r_d      = '0;
          c_d      = '0;
          top_d    = '0;
          left_d   = '0;
          bottom_d = rows_i - RW'(1);
          right_d  = cols_i - CW'(1);
          cols_d   = cols_i;
          remain_d = total_i;
          addr_d   = '0;
        end
      end
      WALK_RUN: begin
        if (last) begin
          state_d = WALK_IDLE;
        end else begin
          remain_d = remain_q - CNT_W'(1);
          unique case (dir_q)
            DIR_RIGHT: begin
              if (c_q == right_q) begin
                dir_d   = DIR_DOWN;
                top_d   = top_q + RW'(1);
                r_d     = r_q + RW'(1);
                one_sel = 1'b0;
              end else begin
                c_d = c_q + CW'(1);
              end
            end
            DIR_DOWN: begin
              if (r_q == bottom_q) begin
                dir_d   = DIR_LEFT;
                right_d = right_q - CW'(1);
                c_d     = c_q - CW'(1);
                sub_sel = 1'b1;
              end else begin
                r_d     = r_q + RW'(1);
                one_sel = 1'b0;
              end
            end
            DIR_LEFT: begin
              if (c_q == left_q) begin
                dir_d    = DIR_UP;
                bottom_d = bottom_q - RW'(1);
                r_d      = r_q - RW'(1);
                one_sel  = 1'b0;
                sub_sel  = 1'b1;
              end else begin
                c_d     = c_q - CW'(1);
                sub_sel = 1'b1;
              end
            end
            DIR_UP: begin
              if (r_q == top_q) begin
                dir_d  = DIR_RIGHT;
                left_d = left_q + CW'(1);
                c_d    = c_q + CW'(1);
              end else begin
                r_d     = r_q - RW'(1);
                one_sel = 1'b0;
                sub_sel = 1'b1;
              end
            end
            default: begin
              dir_d = DIR_RIGHT;
            end
          endcase
          addr_d = step_addr;
        end
      end
      default: begin
        state_d = WALK_IDLE;
      end
    endcase
  end

  assign stat_o.busy  = (state_q == WALK_RUN);
  assign stat_o.rd_en = (state_q == WALK_RUN);
  assign stat_o.last  = last;
  assign rd_addr_o    = addr_q;

endmodule

>>> rtl/core/spom_checker.sv
// ----------------------------------------------------------------------------
// spom_checker
// Port-level checks on the result stream of the spiral-order matrix reader.
// ----------------------------------------------------------------------------
module spom_checker #(
  parameter int DATA_WIDTH = spom_pkg::DATA_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           busy_o,
  input logic                           spiral_valid_o,
  input logic signed [DATA_WIDTH-1:0]   spiral_value_o,
  input logic                           is_last_o
);

  // drain is gap-free up to the last beat
  a_drain_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spiral_valid_o && !is_last_o |=> spiral_valid_o)
    else $error("gap in spiral drain");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spiral_valid_o && is_last_o |=> !spiral_valid_o)
    else $error("beat after last");

  a_busy_mid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spiral_valid_o && !is_last_o |-> busy_o)
    else $error("not busy while drain still running");

  a_burst_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(spiral_valid_o) |-> $past(busy_o))
    else $error("burst without preceding busy");

  a_value_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spiral_valid_o |-> !$isunknown(spiral_value_o))
    else $error("unknown value on a spiral beat");

endmodule

bind spiral_order_matrix_reader spom_checker #(.DATA_WIDTH(DATA_WIDTH)) u_spom_checker (.*);

>>> tb/spiral_order_matrix_reader_test.sv
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader_test
// Self-checking bench for the spiral-order matrix reader: matrices are loaded
// row-major through start_i and element_value_i and every streamed beat is checked
// against a spiral order built in the bench from its own copy of the store.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_test;
  import spom_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int CELLS       = MAX_ROWS_DEF * MAX_COLUMNS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 6;
  localparam int RANDOM_LOAD = 150;

  typedef logic signed [DW-1:0] elem_t;
  typedef struct {
    elem_t value;
    logic  last;
  } spiral_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  elem_t                 element_value_i;
  logic                  spiral_valid_o;
  elem_t                 spiral_value_o;
  logic                  is_last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  // bench copy of the block state
  elem_t                 matrix_mem [CELLS];
  int                    loaded_n;
  logic [CFG_W-1:0]      rows_raw;
  logic [CFG_W-1:0]      cols_raw;
  spiral_beat_t          spiral_due_q [$];
  spiral_beat_t          due_beat;

  int fail_n;
  int elem_n;
  int beat_n;
  int matrix_n;
  int cycle_n;

  spiral_order_matrix_reader u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .element_value_i (element_value_i),
    .spiral_valid_o  (spiral_valid_o),
    .spiral_value_o  (spiral_value_o),
    .is_last_o       (is_last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_n);
      $display("spiral_order_matrix_reader test failed");
      $finish;
    end
  end

  function automatic int clamp_dim(logic [CFG_W-1:0] raw, int max_dim);
    if (raw == '0) begin
      return 1;
    end
    if (int'(raw) > max_dim) begin
      return max_dim;
    end
    return int'(raw);
  endfunction

  function automatic void add_beat(elem_t v, logic last_beat);
    spiral_beat_t b;
    b.value = v;
    b.last  = last_beat;
    spiral_due_q = {spiral_due_q, b};
  endfunction

  function automatic void queue_spiral(int rows, int cols);
    int total;
    int n;
    int k;
    int top;
    int left;
    int bottom;
    int right;
    total  = rows * cols;
    n      = 0;
    top    = 0;
    left   = 0;
    bottom = rows - 1;
    right  = cols - 1;
    while (n < total) begin
      for (k = left; k <= right && n < total; k++) begin
        add_beat(matrix_mem[top * cols + k], n + 1 == total);
        n++;
      end
      top++;
      for (k = top; k <= bottom && n < total; k++) begin
        add_beat(matrix_mem[k * cols + right], n + 1 == total);
        n++;
      end
      right--;
      for (k = right; k >= left && n < total; k--) begin
        add_beat(matrix_mem[bottom * cols + k], n + 1 == total);
        n++;
      end
      bottom--;
      for (k = bottom; k >= top && n < total; k--) begin
        add_beat(matrix_mem[k * cols + left], n + 1 == total);
        n++;
      end
      left++;
    end
  endfunction

  // size in effect at each element; shrinking below the load emits on the next element
  function automatic void track_element(elem_t v);
    int rows;
    int cols;
    rows = clamp_dim(rows_raw, MAX_ROWS_DEF);
    cols = clamp_dim(cols_raw, MAX_COLUMNS_DEF);
    if (loaded_n < CELLS) begin
      matrix_mem[loaded_n] = v;
    end
    loaded_n++;
    elem_n++;
    if (loaded_n >= rows * cols) begin
      loaded_n = 0;
      matrix_n++;
      queue_spiral(rows, cols);
    end
  endfunction

  function automatic int size_total();
    return clamp_dim(rows_raw, MAX_ROWS_DEF) * clamp_dim(cols_raw, MAX_COLUMNS_DEF);
  endfunction

  // start stays high on return; the caller sends again or lowers it
  task automatic send_element(elem_t v);
    start_i         <= 1'b1;
    element_value_i <= v;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    track_element(v);
  endtask

  task automatic hold_off(int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_quiet();
    start_i <= 1'b0;
    while (spiral_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_size_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == REG_ROW_COUNT) begin
      rows_raw = val;
    end else begin
      cols_raw = val;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    write_size_reg(REG_ROW_COUNT, rows);
    write_size_reg(REG_COLUMN_COUNT, cols);
  endtask

  // random elements in bursts with random gaps; gapless runs back to back
  task automatic send_run(int count, bit gapless);
    int remaining;
    int burst;
    int gap;
    remaining = count;
    while (remaining > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && remaining > 0) begin
        send_element(elem_t'($urandom));
        burst--;
        remaining--;
      end
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        hold_off(gap);
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_size_raw();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return CFG_W'($urandom_range(9, 15));
    end
    if (pick >= 8) begin
      return CFG_W'($urandom_range(5, 8));
    end
    return CFG_W'($urandom_range(1, 4));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && spiral_valid_o) begin
      if (spiral_due_q.size() == 0) begin
        $display("%0t: unexpected beat, actual value %0d last %b", $time,
                 spiral_value_o, is_last_o);
        fail_n++;
      end else begin
        due_beat = spiral_due_q.pop_front();
        beat_n++;
        if (spiral_value_o !== due_beat.value) begin
          $display("%0t: spiral_value expected %0d actual %0d", $time,
                   due_beat.value, spiral_value_o);
          fail_n++;
        end
        if (is_last_o !== due_beat.last) begin
          $display("%0t: is_last expected %b actual %b", $time,
                   due_beat.last, is_last_o);
          fail_n++;
        end
      end
    end
  end

  task automatic test_single_cell();
    send_element(32'sh7fff_ffff);
    wait_quiet();
  endtask

  task automatic test_extreme_values();
    set_size(4'd2, 4'd2);
    send_element('0);
    send_element('1);
    send_element({1'b1, {(DW-1){1'b0}}});
    send_element({1'b0, {(DW-1){1'b1}}});
    wait_quiet();
  endtask

  // zero reads as one, above eight reads as eight
  task automatic test_size_clamp();
    set_size(4'd0, 4'd15);
    send_run(8, 1'b1);
    wait_quiet();
    set_size(4'd15, 4'd0);
    send_run(8, 1'b0);
    wait_quiet();
  endtask

  task automatic test_resize_mid_load();
    set_size(4'd3, 4'd3);
    send_run(3, 1'b1);
    wait_quiet();
    write_size_reg(REG_ROW_COUNT, 4'd1);
    send_element(elem_t'($urandom));
    wait_quiet();
  endtask

  task automatic test_random_matrices();
    int random_n;
    int total;
    int part;
    bit gapless;
    random_n = 0;
    wait_quiet();
    set_size(4'd8, 4'd8);
    send_run(64, 1'b0);
    random_n += 64;
    while (random_n < RANDOM_LOAD) begin
      gapless = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        wait_quiet();
        set_size(pick_size_raw(), pick_size_raw());
      end
      total = size_total();
      if (total > 1 && $urandom_range(0, 5) == 0) begin
        part = $urandom_range(1, total - 1);
        send_run(part, gapless);
        random_n += part;
        wait_quiet();
        write_size_reg($urandom_range(0, 1) ? REG_ROW_COUNT : REG_COLUMN_COUNT,
                       pick_size_raw());
        total = (size_total() > loaded_n) ? size_total() - loaded_n : 1;
      end
      send_run(total, gapless);
      random_n += total;
    end
    wait_quiet();
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    element_value_i = '0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_wdata_i     = '0;
    rows_raw        = 4'd1;
    cols_raw        = 4'd1;
    loaded_n        = 0;
    fail_n          = 0;
    elem_n          = 0;
    beat_n          = 0;
    matrix_n        = 0;
    cycle_n         = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_cell();
    test_extreme_values();
    test_size_clamp();
    test_resize_mid_load();
    test_random_matrices();

    $display("Covered %0d matrices from 1x1 to 8x8, %0d elements loaded, %0d beats checked,",
             matrix_n, elem_n, beat_n);
    $display("with zero and oversize sizes, a shrink during a load and random idle gaps.");
    if (spiral_due_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, spiral_due_q.size());
    end
    if (fail_n == 0 && spiral_due_q.size() == 0) begin
      $display("spiral_order_matrix_reader test passed");
    end else begin
      $display("spiral_order_matrix_reader test failed");
    end
    $finish;
  end

endmodule
